>>> hdl/stbs_pkg.sv
`timescale 1ns / 1ps
package stbs_pkg;

	localparam int TABLE_DEPTH_DEF = 1024;
	localparam int VALUE_W = 32;
	localparam int INDEX_W = 10;
	localparam int COUNT_W = 11;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_SEARCH = 1'b1;

endpackage

>>> hdl/stbs_ram.sv
`timescale 1ns / 1ps
module stbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hdl/sorted_table_binary_search_top.sv
`timescale 1ns / 1ps
// Binary search over a sorted table held in one synchronous RAM.
// A write beat gives no result; busy stays low.
// A search beat gives its done strobe after P probes, where P is the
// number of probes, at most clog2(TABLE_DEPTH) + 1 (11 for 1024 entries): one RAM read per probe.
// A search with element_count 0 gives its result in the next cycle. The receiver cannot stall.
// Reset clears element_count and the control state; table contents are undefined until written.
module sorted_table_binary_search_top #(
	parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic kind,
	input logic [stbs_pkg::INDEX_W-1:0] entry_index,
	input logic signed [stbs_pkg::VALUE_W-1:0] write_value,
	input logic signed [stbs_pkg::VALUE_W-1:0] search_key,
	output logic done,
	output logic found,
	output logic [stbs_pkg::INDEX_W-1:0] position,
	input logic cfg_we,
	input logic [stbs_pkg::COUNT_W-1:0] cfg_wdata
);
	import stbs_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int LW = AW + 2;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SEARCH = 1'b1;

	logic state_q;
	logic [COUNT_W-1:0] element_count_q;
	logic signed [LW-1:0] low_q, high_q, mid_q;
	logic signed [VALUE_W-1:0] key_q;
	logic done_q, found_q;
	logic [INDEX_W-1:0] position_q;

	logic accept;
	logic [31:0] count32, n32;
	logic signed [LW-1:0] high0, mid0;
	logic [AW+INDEX_W-1:0] idx_ext;
	logic write_ok;
	logic ram_we;
	logic [AW-1:0] waddr, raddr;
	logic [VALUE_W-1:0] rdata;
	logic signed [VALUE_W-1:0] entry;
	logic key_lt, key_gt;
	logic signed [LW-1:0] nlow, nhigh, nmid;
	logic signed [LW:0] nsum;

	assign accept = start && !busy;
	assign busy = (state_q != ST_IDLE);

	// Writes beyond the table are dropped.
	assign idx_ext = (AW + INDEX_W)'(entry_index);
	assign write_ok = 32'(entry_index) < 32'(TABLE_DEPTH);
	assign ram_we = accept && (kind == KIND_WRITE) && write_ok;
	assign waddr = idx_ext[AW-1:0];

	// A count above the table depth is clamped to the depth.
	assign count32 = 32'(element_count_q);
	assign n32 = (count32 > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : count32;
	assign high0 = LW'(n32) - LW'(1);
	assign mid0 = high0 >>> 1;

	assign entry = $signed(rdata);
	assign key_lt = key_q < entry;
	assign key_gt = key_q > entry;
	assign nlow = key_gt ? (mid_q + LW'(1)) : low_q;
	assign nhigh = key_lt ? (mid_q - LW'(1)) : high_q;
	assign nsum = {nlow[LW-1], nlow} + {nhigh[LW-1], nhigh};
	assign nmid = nsum[LW:1];

	always_comb begin
		raddr = mid0[AW-1:0];
		if (state_q == ST_SEARCH) begin
			raddr = nmid[AW-1:0];
		end
	end

	stbs_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(waddr),
		.wdata(write_value),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			element_count_q <= '0;
		end else if (cfg_we) begin
			element_count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && (kind == KIND_SEARCH)) begin
						if (n32 == 32'd0) begin
							done_q <= 1'b1;
						end else begin
							state_q <= ST_SEARCH;
						end
					end
				end
				ST_SEARCH: begin
					if ((!key_lt && !key_gt) || (nlow > nhigh)) begin
						done_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept && (kind == KIND_SEARCH)) begin
					key_q <= search_key;
					low_q <= '0;
					high_q <= high0;
					mid_q <= mid0;
					found_q <= 1'b0;
					position_q <= '0;
				end
			end
			ST_SEARCH: begin
				low_q <= nlow;
				high_q <= nhigh;
				mid_q <= nmid;
				// The read data always belongs to the probe held in mid_q.
				found_q <= !key_lt && !key_gt;
				position_q <= (!key_lt && !key_gt) ? INDEX_W'(mid_q) : '0;
			end
			default: begin
				found_q <= 1'b0;
			end
		endcase
	end

	assign done = done_q;
	assign found = found_q;
	assign position = position_q;

endmodule

>>> hdl/stbs_checker.sv
`timescale 1ns / 1ps
module stbs_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic kind,
	input logic done,
	input logic found,
	input logic [stbs_pkg::INDEX_W-1:0] position
);
	import stbs_pkg::*;

	// A result beat only ever appears once the search has finished.
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result beat while a search is still running");

	assert property (@(posedge clk) disable iff (!arst_n)
		(done && !found) |-> (position == '0))
		else $error("miss reported with a nonzero position");

	// A write beat never produces a result.
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (kind == KIND_WRITE)) |=> !done)
		else $error("write beat produced a result");

	assert property (@(posedge clk) disable iff (!arst_n) $rose(busy) |-> !done)
		else $error("result beat at the start of a search");

endmodule

bind sorted_table_binary_search_top stbs_checker u_stbs_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.kind(kind),
	.done(done),
	.found(found),
	.position(position)
);

>>> bench/search_checker.sv
`timescale 1ns / 1ps
module search_checker #(
	parameter int DEPTH = stbs_pkg::TABLE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic kind,
	input logic [stbs_pkg::INDEX_W-1:0] entry_index,
	input logic signed [stbs_pkg::VALUE_W-1:0] write_value,
	input logic signed [stbs_pkg::VALUE_W-1:0] search_key,
	input logic done,
	input logic found,
	input logic [stbs_pkg::INDEX_W-1:0] position,
	input logic cfg_we,
	input logic [stbs_pkg::COUNT_W-1:0] cfg_wdata,
	output int pending_results,
	output int mismatches
);
	import stbs_pkg::*;

	typedef struct packed {
		logic hit;
		logic [INDEX_W-1:0] slot;
	} lookup_t;

	logic signed [VALUE_W-1:0] table_copy [DEPTH];
	logic [COUNT_W-1:0] count_copy;
	lookup_t awaited [$];

	// Probe order is mid = (lo + hi) / 2 over the entries in use, stopping at the first match.
	function automatic lookup_t bisect(logic signed [VALUE_W-1:0] key);
		int lo;
		int hi;
		int mid;
		bit stop;
		lookup_t r;
		r = '0;
		lo = 0;
		hi = (int'(count_copy) > DEPTH ? DEPTH : int'(count_copy)) - 1;
		stop = 1'b0;
		while (!stop && lo <= hi) begin
			mid = (lo + hi) / 2;
			if (key < table_copy[mid]) begin
				hi = mid - 1;
			end else if (key > table_copy[mid]) begin
				lo = mid + 1;
			end else begin
				r.hit = 1'b1;
				r.slot = mid[INDEX_W-1:0];
				stop = 1'b1;
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		lookup_t want;
		int taken;
		int given;
		int bad;
		if (!arst_n) begin
			awaited.delete();
			count_copy = '0;
			pending_results <= 0;
			mismatches <= 0;
		end else begin
			taken = 0;
			given = 0;
			bad = 0;
			if (done) begin
				if (awaited.size() == 0) begin
					$display("%0t: unexpected result: expected none, actual found=%0d position=%0d",
						$time, found, position);
					bad++;
				end else begin
					want = awaited.pop_front();
					given = 1;
					if (found !== want.hit) begin
						$display("%0t: found mismatch: expected %0d, actual %0d",
							$time, want.hit, found);
						bad++;
					end
					if (position !== want.slot) begin
						$display("%0t: position mismatch: expected %0d, actual %0d",
							$time, want.slot, position);
						bad++;
					end
				end
			end
			if (cfg_we)
				count_copy = cfg_wdata;
			// A beat is taken when start is high and busy is low.
			if (start && !busy) begin
				if (kind == KIND_SEARCH) begin
					awaited.push_back(bisect(search_key));
					taken = 1;
				end else if (entry_index < DEPTH) begin
					table_copy[entry_index] = write_value;
				end
			end
			pending_results <= pending_results + taken - given;
			mismatches <= mismatches + bad;
		end
	end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import stbs_pkg::*;

	localparam int DEPTH = TABLE_DEPTH_DEF;
	localparam int SETTLE = 16;
	localparam int CYCLE_LIMIT = 600000;
	localparam int RANDOM_ITEMS = 450;
	localparam int MAX_GAP = 17;
	localparam int FILL_WIDE = 0;
	localparam int FILL_DENSE = 1;
	localparam int FILL_SHUFFLED = 2;
	localparam logic signed [VALUE_W-1:0] KEY_MIN = 32'sh8000_0000;
	localparam logic signed [VALUE_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

	logic clk = 1'b0;
	logic arst_n;
	logic start = 1'b0;
	logic busy;
	logic kind = KIND_WRITE;
	logic [INDEX_W-1:0] entry_index = '0;
	logic signed [VALUE_W-1:0] write_value = '0;
	logic signed [VALUE_W-1:0] search_key = '0;
	logic done;
	logic found;
	logic [INDEX_W-1:0] position;
	logic cfg_we = 1'b0;
	logic [COUNT_W-1:0] cfg_wdata = '0;

	int outstanding;
	int mismatches;
	int cycles = 0;
	int sent_random = 0;
	bit rush = 1'b0;
	// Values written so far, used only to pick keys that hit.
	logic signed [VALUE_W-1:0] mirror [DEPTH];

	sorted_table_binary_search_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.entry_index(entry_index),
		.write_value(write_value),
		.search_key(search_key),
		.done(done),
		.found(found),
		.position(position),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	search_checker #(.DEPTH(DEPTH)) scoreboard (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.entry_index(entry_index),
		.write_value(write_value),
		.search_key(search_key),
		.done(done),
		.found(found),
		.position(position),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.pending_results(outstanding),
		.mismatches(mismatches)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic idle_gap();
		int gap;
		gap = rush ? 0 : ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, MAX_GAP));
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Start stays high when the next beat follows with no gap.
	task automatic issue(logic k, logic [INDEX_W-1:0] idx, logic signed [VALUE_W-1:0] wv,
			logic signed [VALUE_W-1:0] key);
		idle_gap();
		start <= 1'b1;
		kind <= k;
		entry_index <= idx;
		write_value <= wv;
		search_key <= key;
		do @(posedge clk); while (busy);
		if (k == KIND_WRITE)
			mirror[idx] = wv;
	endtask

	task automatic write_entry(logic [INDEX_W-1:0] idx, logic signed [VALUE_W-1:0] v);
		issue(KIND_WRITE, idx, v, $urandom);
	endtask

	task automatic lookup(logic signed [VALUE_W-1:0] key);
		issue(KIND_SEARCH, INDEX_W'($urandom), $urandom, key);
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// The count is only changed with the block idle, after the last search has left the pipe.
	task automatic set_count(int n);
		drain();
		repeat (SETTLE) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= n[COUNT_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic fill_table(int m, int mode);
		longint level;
		longint stride;
		int unsigned step_cap;
		int i;
		stride = (mode == FILL_DENSE) ? 64'sd3 : 64'sd4294967296 / (m + 1);
		step_cap = (stride * 2 > 64'sd4294967295) ? 32'hFFFF_FFFF : 32'(stride * 2);
		if (mode == FILL_DENSE)
			level = longint'($signed($urandom));
		else if ($urandom_range(0, 1) == 0)
			level = longint'(KEY_MIN);
		else
			level = longint'(KEY_MIN) + $urandom_range(0, 32'(stride));
		for (i = 0; i < m; i++) begin
			if (mode == FILL_SHUFFLED) begin
				write_entry(i[INDEX_W-1:0], $urandom);
			end else begin
				if (level > longint'(KEY_MAX) || (i == m - 1 && $urandom_range(0, 3) == 0))
					level = longint'(KEY_MAX);
				write_entry(i[INDEX_W-1:0], level[VALUE_W-1:0]);
				// Now and then a zero step leaves a run of equal entries.
				if ($urandom_range(0, 7) != 0)
					level += $urandom_range(0, step_cap);
			end
		end
	endtask

	function automatic logic signed [VALUE_W-1:0] pick_key(int m);
		logic signed [VALUE_W-1:0] hit;
		hit = (m > 0) ? mirror[$urandom_range(0, m - 1)] : $urandom;
		case ($urandom_range(0, 9))
		0, 1, 2, 3: return hit;
		4: return hit + 1;
		5: return hit - 1;
		6: return $urandom_range(0, 1) ? KEY_MIN : KEY_MAX;
		default: return $urandom;
		endcase
	endfunction

	task automatic run_phase();
		int n;
		int m;
		int mode;
		int items;
		case ($urandom_range(0, 11))
		0: n = 0;
		1: n = 1;
		2: n = 2;
		3, 4, 5, 6: n = $urandom_range(3, 40);
		7: n = $urandom_range(41, 300);
		8: n = DEPTH;
		9: n = $urandom_range(DEPTH + 1, 2047);
		10: n = 2047;
		default: n = $urandom_range(1, 8);
		endcase
		m = (n > DEPTH) ? DEPTH : n;
		set_count(n);
		if ($urandom_range(0, 5) == 0)
			mode = FILL_SHUFFLED;
		else if ($urandom_range(0, 2) == 0)
			mode = FILL_DENSE;
		else
			mode = FILL_WIDE;
		rush = (m > 300) || ($urandom_range(0, 1) == 0);
		fill_table(m, mode);
		rush = ($urandom_range(0, 4) == 0);
		items = $urandom_range(15, 40);
		repeat (items) begin
			if ($urandom_range(0, 24) == 0)
				drain();
			// A stray write either lands past the entries in use or may break their order.
			if ($urandom_range(0, 7) == 0)
				write_entry(INDEX_W'($urandom), $urandom);
			else
				lookup(pick_key(m));
			sent_random++;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty table: nothing can be found.
		set_count(0);
		lookup(KEY_MIN);
		lookup(KEY_MAX);
		lookup('0);

		write_entry(10'd1023, KEY_MAX);
		write_entry(10'd0, KEY_MIN);
		set_count(1);
		lookup(KEY_MIN);
		lookup(KEY_MAX);
		lookup('0);

		write_entry(10'd1, '0);
		set_count(2);
		lookup('0);
		lookup(KEY_MIN);
		lookup(-32'sd1);

		write_entry(10'd2, KEY_MAX);
		set_count(3);
		lookup(KEY_MAX);
		lookup(KEY_MAX - 1);

		while (sent_random < RANDOM_ITEMS)
			run_phase();

		drain();
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

>>> files.f
hdl/stbs_pkg.sv
hdl/stbs_ram.sv
hdl/sorted_table_binary_search_top.sv
hdl/stbs_checker.sv
bench/search_checker.sv
bench/tb_top.sv
